@@ hw/rtl/framed_packet_receiver_defines.svh @@
// Assertion macros shared by the frame receiver RTL.
// Each use sits on a line of its own; the macro supplies the terminating semicolon.
`ifndef FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on i_clk, idle during reset
`define FPR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// Next-cycle implication, sampled on i_clk, idle during reset
`define FPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`else

`define FPR_ASSERT_IMPL(lbl, ante, cons)
`define FPR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/fpr_pkg.sv @@
`timescale 1ns / 1ps

package fpr_pkg;

    localparam int FRAME_BUF_LEN  = 64;
    localparam int FRAME_OVERHEAD = 8;
    localparam int MAX_PAYLOAD    = FRAME_BUF_LEN - FRAME_OVERHEAD;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W     = $clog2(MAX_PAYLOAD);
    localparam int SUM_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [BYTE_W-1:0] ACK_KIND = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST  = 3'd0,
        CFG_HEADER_SECOND = 3'd1,
        CFG_TAIL_FIRST    = 3'd2,
        CFG_TAIL_SECOND   = 3'd3,
        CFG_ACK_ENABLE    = 3'd4
    } t_cfg_idx;

    // Payload store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_store_wr;

    // Description of a validated frame handed to the readout
    typedef struct packed {
        logic [BYTE_W-1:0] kind;
        logic [CNT_W-1:0]  len;
        logic              is_ack;
        logic              send_ack;
    } t_frame_desc;

endpackage

@@ hw/rtl/fpr_readout.sv @@
`timescale 1ns / 1ps
`include "framed_packet_receiver_defines.svh"

module fpr_readout (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fpr_pkg::t_store_wr          i_wr,
    input  logic                        i_start,
    input  fpr_pkg::t_frame_desc        i_desc,
    output logic                        o_busy,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [fpr_pkg::BYTE_W-1:0]  o_frame_kind,
    output logic [fpr_pkg::CNT_W-1:0]   o_payload_count,
    output logic [fpr_pkg::CNT_W-1:0]   o_byte_position,
    output logic [fpr_pkg::BYTE_W-1:0]  o_payload_value,
    output logic                        o_carries_payload,
    output logic                        o_is_ack_frame,
    output logic                        o_send_ack,
    output logic                        o_last_of_frame
);
    import fpr_pkg::*;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_ISSUE,
        RD_LOAD
    } t_rd_state;

    t_rd_state         r_state;
    t_frame_desc       r_desc;
    logic [CNT_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];

    logic              rd_en;
    logic              real_data;
    logic [CNT_W-1:0]  idx_last;
    logic              is_last;
    logic              can_load;
    logic              load_now;

    assign rd_en     = (r_state == RD_ISSUE);
    assign real_data = (r_desc.len != '0);
    assign idx_last  = real_data ? (r_desc.len - CNT_W'(1)) : '0;
    assign is_last   = (r_idx == idx_last);
    assign can_load  = !o_valid || !i_stall;
    assign load_now  = (r_state == RD_LOAD) && can_load;
    assign o_busy    = (r_state != RD_IDLE);

    // Payload store: one write port from the parser, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RD_IDLE;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            // Raise valid on a load, drop it once the transaction is taken
            if (load_now) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                RD_IDLE: begin
                    if (i_start) begin
                        r_desc  <= i_desc;
                        r_idx   <= '0;
                        r_state <= RD_ISSUE;
                    end
                end
                RD_ISSUE: begin
                    r_state <= RD_LOAD;
                end
                RD_LOAD: begin
                    if (can_load) begin
                        o_frame_kind      <= r_desc.kind;
                        o_payload_count   <= r_desc.len;
                        o_byte_position   <= real_data ? r_idx : '0;
                        o_payload_value   <= real_data ? r_rd_data : '0;
                        o_carries_payload <= real_data;
                        o_is_ack_frame    <= r_desc.is_ack;
                        o_send_ack        <= r_desc.send_ack;
                        o_last_of_frame   <= is_last;
                        if (is_last) begin
                            r_state <= RD_IDLE;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= RD_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= RD_IDLE;
                end
            endcase
        end
    end

    `FPR_ASSERT_IMPL(a_start_when_idle, i_start, r_state == RD_IDLE)
    `FPR_ASSERT_IMPL(a_no_write_in_readout, o_busy, !i_wr.en)
    `FPR_ASSERT_IMPL(a_idx_in_frame, o_busy && real_data, r_idx < r_desc.len)
    `FPR_ASSERT_NEXT(a_last_ends_readout, load_now && is_last, !o_busy && o_valid && o_last_of_frame)

endmodule

@@ hw/rtl/framed_packet_receiver.sv @@
`timescale 1ns / 1ps
// Byte-serial frame receiver.
// Input channel: one received byte per transaction (i_valid / o_stall, i_rx_byte).
// Frames are header1, header2, type, length, payload, checksum high, checksum low,
// tail1, tail2; the checksum is the 16-bit wrapping sum of type, length and payload.
// Output channel: o_valid / i_stall with one result per payload byte of each good
// frame, or a single empty result for a zero-length frame; o_last_of_frame marks
// the final result. Bad headers, tails, lengths or checksums drop the frame quietly.
// Configuration: write i_cfg_data to register i_cfg_idx with i_cfg_we, only while idle.
// Throughput: one byte per cycle while a frame is being received. After the tail2
// byte of a good frame the input stalls while the payload store is read out: each
// result passes through a store read (RD_ISSUE) and a load of the output register
// (RD_LOAD), which waits while the receiver stalls. The input reopens once the
// last result sits in the output register.
// A stall from the receiver holds the output register and pauses the readout.
// Reset (synchronous, active low) returns the parser to hunting for header1 and
// clears the configuration registers; the payload store needs no clearing pass.
`include "framed_packet_receiver_defines.svh"

module framed_packet_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fpr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [fpr_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [fpr_pkg::BYTE_W-1:0]     o_frame_kind,
    output logic [fpr_pkg::CNT_W-1:0]      o_payload_count,
    output logic [fpr_pkg::CNT_W-1:0]      o_byte_position,
    output logic [fpr_pkg::BYTE_W-1:0]     o_payload_value,
    output logic                           o_carries_payload,
    output logic                           o_is_ack_frame,
    output logic                           o_send_ack,
    output logic                           o_last_of_frame
);
    import fpr_pkg::*;

    typedef enum logic [3:0] {
        PH_HEAD1,
        PH_HEAD2,
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_SUMHI,
        PH_SUMLO,
        PH_TAIL1,
        PH_TAIL2
    } t_phase;

    // Configuration registers
    logic [BYTE_W-1:0] r_header_first;
    logic [BYTE_W-1:0] r_header_second;
    logic [BYTE_W-1:0] r_tail_first;
    logic [BYTE_W-1:0] r_tail_second;
    logic              r_ack_enable;

    // Parser state
    t_phase            r_phase;
    logic [BYTE_W-1:0] r_type;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_fill;
    logic [SUM_W-1:0]  r_run_sum;
    logic [SUM_W-1:0]  r_rcv_sum;

    logic              busy;
    logic              accept;
    logic [CNT_W-1:0]  fill_inc;
    logic [SUM_W-1:0]  sum_add;
    logic              frame_good;
    t_store_wr         store_wr;
    t_frame_desc       desc;

    // Hold the input off while a frame is read out of the payload store
    assign o_stall  = busy;
    assign accept   = i_valid && !o_stall;
    assign fill_inc = r_fill + CNT_W'(1);
    assign sum_add  = r_run_sum + SUM_W'(i_rx_byte);

    // Tail2 matches and the received checksum agrees with the running sum
    assign frame_good = accept && (r_phase == PH_TAIL2) &&
                        (i_rx_byte == r_tail_second) && (r_rcv_sum == r_run_sum);

    // Store payload bytes at the fill position; never past the end of the store
    always_comb begin
        store_wr.en   = accept && (r_phase == PH_DATA) && (r_fill < CNT_W'(MAX_PAYLOAD));
        store_wr.addr = r_fill[ADDR_W-1:0];
        store_wr.data = i_rx_byte;
    end

    always_comb begin
        desc.kind     = r_type;
        desc.len      = r_len;
        desc.is_ack   = (r_type == ACK_KIND);
        desc.send_ack = (r_type != ACK_KIND) && r_ack_enable;
    end

    // Configuration writes; indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= '0;
            r_header_second <= '0;
            r_tail_first    <= '0;
            r_tail_second   <= '0;
            r_ack_enable    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_header_second <= i_cfg_data;
                CFG_TAIL_FIRST:    r_tail_first    <= i_cfg_data;
                CFG_TAIL_SECOND:   r_tail_second   <= i_cfg_data;
                CFG_ACK_ENABLE:    r_ack_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Frame parser: advance on accepted bytes (the data phase takes one per payload byte), drop
    // back to header1 hunting on any mismatch. Payload fields are always rewritten before use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEAD1;
            r_type    <= '0;
            r_len     <= '0;
            r_fill    <= '0;
            r_run_sum <= '0;
            r_rcv_sum <= '0;
        end else if (accept) begin
            unique case (r_phase)
                PH_HEAD1: begin
                    if (i_rx_byte == r_header_first) begin
                        r_phase <= PH_HEAD2;
                    end
                end
                PH_HEAD2: begin
                    r_phase <= (i_rx_byte == r_header_second) ? PH_TYPE : PH_HEAD1;
                end
                PH_TYPE: begin
                    r_type    <= i_rx_byte;
                    r_run_sum <= SUM_W'(i_rx_byte);
                    r_phase   <= PH_LEN;
                end
                PH_LEN: begin
                    if (i_rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
                        r_phase <= PH_HEAD1;
                    end else begin
                        r_len     <= i_rx_byte[CNT_W-1:0];
                        r_fill    <= '0;
                        r_run_sum <= sum_add;
                        r_phase   <= (i_rx_byte == '0) ? PH_SUMHI : PH_DATA;
                    end
                end
                PH_DATA: begin
                    r_fill    <= fill_inc;
                    r_run_sum <= sum_add;
                    if (fill_inc >= r_len) begin
                        r_phase <= PH_SUMHI;
                    end
                end
                PH_SUMHI: begin
                    r_rcv_sum <= {i_rx_byte, 8'h00};
                    r_phase   <= PH_SUMLO;
                end
                PH_SUMLO: begin
                    r_rcv_sum <= {r_rcv_sum[SUM_W-1:BYTE_W], i_rx_byte};
                    r_phase   <= PH_TAIL1;
                end
                PH_TAIL1: begin
                    r_phase <= (i_rx_byte == r_tail_first) ? PH_TAIL2 : PH_HEAD1;
                end
                PH_TAIL2: begin
                    // Good or bad, the frame ends here
                    r_phase <= PH_HEAD1;
                end
                default: begin
                    r_phase <= PH_HEAD1;
                end
            endcase
        end
    end

    fpr_readout u_readout (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_wr              (store_wr),
        .i_start           (frame_good),
        .i_desc            (desc),
        .o_busy            (busy),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_kind      (o_frame_kind),
        .o_payload_count   (o_payload_count),
        .o_byte_position   (o_byte_position),
        .o_payload_value   (o_payload_value),
        .o_carries_payload (o_carries_payload),
        .o_is_ack_frame    (o_is_ack_frame),
        .o_send_ack        (o_send_ack),
        .o_last_of_frame   (o_last_of_frame)
    );

    `FPR_ASSERT_NEXT(a_good_frame_stalls_input, frame_good, o_stall && (r_phase == PH_HEAD1))
    `FPR_ASSERT_IMPL(a_fill_within_length, r_phase == PH_DATA, r_fill < r_len)
    `FPR_ASSERT_IMPL(a_length_fits_store, r_phase == PH_DATA, r_len <= CNT_W'(MAX_PAYLOAD))

endmodule

@@ tb/framed_packet_receiver_tb.sv @@
`timescale 1ns / 1ps

module framed_packet_receiver_tb;
    import fpr_pkg::*;

    localparam int IDLE_LIMIT    = 3000;  // cycles with no transaction on either side
    localparam int LONG_HOLD     = 400;   // receiver hold-off that backs the block up
    localparam int SETTLE_CYCLES = 8;     // settling margin after the last result

    typedef enum logic [3:0] {
        HUNT_HEAD1,
        HUNT_HEAD2,
        TAKE_KIND,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_SUM_HI,
        TAKE_SUM_LO,
        CHECK_TAIL1,
        CHECK_TAIL2
    } t_rx_phase;

    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_HEAD2,
        FLAW_LEN,
        FLAW_SUM,
        FLAW_TAIL1,
        FLAW_TAIL2
    } t_frame_flaw;

    typedef struct packed {
        logic [BYTE_W-1:0] kind;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  position;
        logic [BYTE_W-1:0] value;
        logic              carries;
        logic              is_ack;
        logic              send_ack;
        logic              last;
    } t_payload_out;

    typedef struct {
        logic [BYTE_W-1:0] value;
        bit                drain_first;  // hold this byte back until every result is out
    } t_rx_slot;

    // DUT ports; the driven inputs are known from time zero
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic [BYTE_W-1:0]     i_rx_byte  = '0;
    logic                  i_stall    = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [BYTE_W-1:0]     o_frame_kind;
    logic [CNT_W-1:0]      o_payload_count;
    logic [CNT_W-1:0]      o_byte_position;
    logic [BYTE_W-1:0]     o_payload_value;
    logic                  o_carries_payload;
    logic                  o_is_ack_frame;
    logic                  o_send_ack;
    logic                  o_last_of_frame;

    framed_packet_receiver dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_frame_kind      (o_frame_kind),
        .o_payload_count   (o_payload_count),
        .o_byte_position   (o_byte_position),
        .o_payload_value   (o_payload_value),
        .o_carries_payload (o_carries_payload),
        .o_is_ack_frame    (o_is_ack_frame),
        .o_send_ack        (o_send_ack),
        .o_last_of_frame   (o_last_of_frame)
    );

    always #2 i_clk = ~i_clk;

    // Configuration as the block should hold it
    logic [BYTE_W-1:0] cfg_head1, cfg_head2, cfg_tail1, cfg_tail2;
    logic              cfg_ack_en;

    // Parser state of the predictor
    t_rx_phase         rx_phase;
    logic [BYTE_W-1:0] held_kind;
    logic [CNT_W-1:0]  held_len;
    int                fill_count;
    logic [SUM_W-1:0]  running_sum;
    logic [SUM_W-1:0]  received_sum;
    logic [BYTE_W-1:0] frame_bytes [MAX_PAYLOAD];

    t_payload_out      payload_due [$];  // results still owed by the block
    t_rx_slot          rx_backlog  [$];  // bytes not yet taken by the block

    int mismatch_count    = 0;
    int idle_cycles       = 0;
    int hold_requests     = 0;  // raised by the stimulus, served by the monitor
    bit idling_on         = 1'b1;

    task automatic note_mismatch(input string msg);
        $display("%0t ns MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            note_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
    endtask

    task automatic restart_parse();
        rx_phase     = HUNT_HEAD1;
        held_kind    = '0;
        held_len     = '0;
        fill_count   = 0;
        running_sum  = '0;
        received_sum = '0;
    endtask

    // Queue one result per stored payload byte, or a single empty one
    task automatic release_frame();
        t_payload_out r;
        int           n;
        n = (held_len != 0) ? int'(held_len) : 1;
        for (int k = 0; k < n; k++) begin
            r.kind     = held_kind;
            r.count    = held_len;
            r.position = (held_len != 0) ? CNT_W'(k) : '0;
            r.value    = (held_len != 0) ? frame_bytes[k] : '0;
            r.carries  = (held_len != 0);
            r.is_ack   = (held_kind == ACK_KIND);
            r.send_ack = (held_kind != ACK_KIND) && cfg_ack_en;
            r.last     = (k == n - 1);
            payload_due.push_back(r);
        end
    endtask

    // Advance the predicted parser by one received byte
    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        case (rx_phase)
            HUNT_HEAD1: begin
                if (b == cfg_head1)
                    rx_phase = HUNT_HEAD2;
            end
            HUNT_HEAD2: begin
                if (b == cfg_head2)
                    rx_phase = TAKE_KIND;
                else
                    restart_parse();
            end
            TAKE_KIND: begin
                held_kind   = b;
                running_sum = SUM_W'(b);
                rx_phase    = TAKE_LEN;
            end
            TAKE_LEN: begin
                if (b > MAX_PAYLOAD) begin
                    restart_parse();
                end else begin
                    held_len    = CNT_W'(b);
                    fill_count  = 0;
                    running_sum = running_sum + SUM_W'(b);
                    rx_phase    = (b == 0) ? TAKE_SUM_HI : TAKE_DATA;
                end
            end
            TAKE_DATA: begin
                if (fill_count < MAX_PAYLOAD)
                    frame_bytes[fill_count] = b;
                fill_count++;
                running_sum = running_sum + SUM_W'(b);
                if (fill_count >= held_len)
                    rx_phase = TAKE_SUM_HI;
            end
            TAKE_SUM_HI: begin
                received_sum = {b, 8'h00};
                rx_phase     = TAKE_SUM_LO;
            end
            TAKE_SUM_LO: begin
                received_sum[7:0] = b;
                rx_phase          = CHECK_TAIL1;
            end
            CHECK_TAIL1: begin
                if (b == cfg_tail1)
                    rx_phase = CHECK_TAIL2;
                else
                    restart_parse();
            end
            CHECK_TAIL2: begin
                if (b == cfg_tail2 && received_sum == running_sum)
                    release_frame();
                restart_parse();
            end
            default: restart_parse();
        endcase
    endtask

    // Driver: present the head of the backlog, hold it while stalled
    always @(posedge i_clk) begin
        bit send_now;
        int gap_left;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_rx_byte(i_rx_byte);
                void'(rx_backlog.pop_front());
            end
            // A stalled transaction stays exactly as it is
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    send_now = 1'b0;
                end else if (rx_backlog.size() == 0) begin
                    send_now = 1'b0;
                end else if (rx_backlog[0].drain_first && payload_due.size() != 0) begin
                    send_now = 1'b0;
                end else if (idling_on && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(1, 18) - 1;
                    send_now = 1'b0;
                end else begin
                    send_now = 1'b1;
                end
                i_valid <= send_now;
                if (send_now)
                    i_rx_byte <= rx_backlog[0].value;
            end
        end
    end

    // Monitor: check each result transaction and drive the receiver stall
    always @(posedge i_clk) begin
        t_payload_out want;
        int           hold_left;
        int           stall_left;
        int           holds_served;
        bit           stall_now;
        if (!i_rst_n) begin
            i_stall      <= 1'b0;
            hold_left    = 0;
            stall_left   = 0;
            holds_served = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (payload_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected result, kind %0d position %0d",
                                            o_frame_kind, o_byte_position));
                end else begin
                    want = payload_due.pop_front();
                    check_field("frame_kind", int'(o_frame_kind), int'(want.kind));
                    check_field("payload_count", int'(o_payload_count), int'(want.count));
                    check_field("byte_position", int'(o_byte_position), int'(want.position));
                    check_field("payload_value", int'(o_payload_value), int'(want.value));
                    check_field("carries_payload", int'(o_carries_payload),
                                int'(want.carries));
                    check_field("is_ack_frame", int'(o_is_ack_frame), int'(want.is_ack));
                    check_field("send_ack", int'(o_send_ack), int'(want.send_ack));
                    check_field("last_of_frame", int'(o_last_of_frame), int'(want.last));
                end
            end
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_now = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_now = 1'b1;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                stall_now  = 1'b1;
            end else begin
                stall_now = 1'b0;
            end
            i_stall <= stall_now;
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("framed_packet_receiver_tb: errors");
                $finish;
            end
        end
    end

    task automatic push_rx(input logic [BYTE_W-1:0] value, input bit drain_first);
        t_rx_slot s;
        s.value       = value;
        s.drain_first = drain_first;
        rx_backlog.push_back(s);
    endtask

    // Build one frame under the current configuration, broken as the flaw asks
    task automatic queue_frame(input logic [BYTE_W-1:0] kind, input int len,
                               input t_frame_flaw flaw, input bit drain_first);
        logic [SUM_W-1:0]  sum;
        logic [BYTE_W-1:0] body [$];
        logic [BYTE_W-1:0] bad;
        bad = BYTE_W'($urandom_range(1, 255));
        push_rx(cfg_head1, drain_first);
        if (flaw == FLAW_HEAD2) begin
            push_rx(cfg_head2 ^ bad, 1'b0);
            return;
        end
        push_rx(cfg_head2, 1'b0);
        push_rx(kind, 1'b0);
        if (flaw == FLAW_LEN) begin
            push_rx(($urandom_range(0, 3) == 0) ? 8'hFF : BYTE_W'($urandom_range(57, 255)),
                    1'b0);
            return;
        end
        push_rx(BYTE_W'(len), 1'b0);
        sum = SUM_W'(kind) + SUM_W'(len);
        for (int k = 0; k < len; k++) begin
            body.push_back(BYTE_W'($urandom));
            sum = sum + SUM_W'(body[k]);
            push_rx(body[k], 1'b0);
        end
        if (flaw == FLAW_SUM)
            sum = sum ^ SUM_W'($urandom_range(1, 65535));
        push_rx(sum[15:8], 1'b0);
        push_rx(sum[7:0], 1'b0);
        if (flaw == FLAW_TAIL1) begin
            push_rx(cfg_tail1 ^ bad, 1'b0);
            return;
        end
        push_rx(cfg_tail1, 1'b0);
        push_rx((flaw == FLAW_TAIL2) ? (cfg_tail2 ^ bad) : cfg_tail2, 1'b0);
    endtask

    // Mostly good frames with random content, some broken ones and line noise
    task automatic queue_random_traffic(input int byte_budget, input bit with_drains);
        int                target;
        int                pick;
        int                len;
        logic [BYTE_W-1:0] kind;
        t_frame_flaw       flaw;
        target = rx_backlog.size() + byte_budget;
        while (rx_backlog.size() < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                repeat ($urandom_range(1, 4))
                    push_rx(BYTE_W'($urandom), 1'b0);
            end else begin
                kind = ($urandom_range(0, 7) == 0) ? ACK_KIND : BYTE_W'($urandom);
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: len = $urandom_range(0, 6);
                    12, 13, 14, 15, 16, 17:               len = $urandom_range(7, 20);
                    18:                                   len = MAX_PAYLOAD;
                    default:                              len = $urandom_range(21, 55);
                endcase
                flaw = (pick < 5) ? t_frame_flaw'($urandom_range(1, 5)) : FLAW_NONE;
                queue_frame(kind, len, flaw, with_drains && $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // Idle means: every byte taken, every result out, readout settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (rx_backlog.size() != 0 || i_valid || payload_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [BYTE_W-1:0] head1, input logic [BYTE_W-1:0] head2,
                                input logic [BYTE_W-1:0] tail1, input logic [BYTE_W-1:0] tail2,
                                input logic [CFG_DATA_W-1:0] ack_word);
        t_cfg_idx              reg_order [5];
        logic [CFG_DATA_W-1:0] reg_value [5];
        reg_order = '{CFG_HEADER_FIRST, CFG_HEADER_SECOND, CFG_TAIL_FIRST,
                      CFG_TAIL_SECOND, CFG_ACK_ENABLE};
        reg_value = '{head1, head2, tail1, tail2, ack_word};
        for (int k = 0; k < 5; k++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_order[k];
            i_cfg_data <= reg_value[k];
        end
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_head1  = head1;
        cfg_head2  = head2;
        cfg_tail1  = tail1;
        cfg_tail2  = tail2;
        cfg_ack_en = ack_word[0];
        @(negedge i_clk);
    endtask

    initial begin
        cfg_head1  = '0;
        cfg_head2  = '0;
        cfg_tail1  = '0;
        cfg_tail2  = '0;
        cfg_ack_en = 1'b0;
        restart_parse();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: all-zero framing, an all-zero empty frame
        queue_frame(8'h00, 0, FLAW_NONE, 1'b0);
        queue_frame(8'h01, 1, FLAW_NONE, 1'b0);
        wait_drained();

        // Directed: one frame or fragment per corner of the parser
        write_config(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h01);
        push_rx(8'h00, 1'b0);                       // stray byte before header1
        queue_frame(8'h01, 2, FLAW_NONE, 1'b0);
        queue_frame(8'h02, 1, FLAW_HEAD2, 1'b0);
        queue_frame(8'h03, 0, FLAW_LEN, 1'b0);
        queue_frame(8'h04, 0, FLAW_NONE, 1'b0);     // empty data frame
        queue_frame(ACK_KIND, 1, FLAW_NONE, 1'b0);
        queue_frame(8'h05, 1, FLAW_SUM, 1'b0);
        queue_frame(8'h06, 1, FLAW_TAIL1, 1'b0);
        queue_frame(8'h07, 1, FLAW_TAIL2, 1'b0);
        queue_frame(8'h80, MAX_PAYLOAD, FLAW_NONE, 1'b0);
        wait_drained();

        // All-ones framing, acknowledges off, upper data bits set on the enable
        write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE);
        queue_random_traffic(30, 1'b0);
        wait_drained();

        // Receiver holds off while bytes keep coming, so the input backs up
        write_config(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01);
        hold_requests++;
        for (int k = 0; k < 6; k++)
            queue_frame(BYTE_W'($urandom), $urandom_range(4, 12), FLAW_NONE, 1'b0);
        queue_random_traffic(20, 1'b0);
        wait_drained();

        // Random framing; some frames wait until the previous results are out
        write_config(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                     BYTE_W'($urandom), CFG_DATA_W'($urandom));
        queue_frame(8'h11, 3, FLAW_NONE, 1'b0);
        queue_frame(8'h12, 2, FLAW_NONE, 1'b1);
        queue_random_traffic(50, 1'b1);
        wait_drained();

        // Final stretch at full rate on both sides
        idling_on = 1'b0;
        write_config(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                     BYTE_W'($urandom), 8'h01);
        queue_random_traffic(40, 1'b0);
        wait_drained();
        repeat (20) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("framed_packet_receiver_tb: clean");
        else
            $display("framed_packet_receiver_tb: errors");
        $finish;
    end

endmodule
